FILE: design/indexed_ordered_list_defines.svh
// ----------------------------------------------------------------------------
// indexed_ordered_list_defines: assertion macros
// Shared assertion macros for the ordered list block. Both macros use the
// clk and arst_n of the module that expands them. They are empty under
// synthesis.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH
`ifndef SYNTHESIS
// Check that holds at every edge out of reset.
`define IOL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("indexed_ordered_list: assertion failed");
// Check that cons holds in the cycle after ante.
`define IOL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error("indexed_ordered_list: assertion failed");
`else
`define IOL_ASSERT(lbl, prop)
`define IOL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg: shared types of the ordered list
// Request codes, status codes and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package iol_pkg;

	localparam int FUNC_W   = 4;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 16;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD_BACK  = 4'd0,
		FN_ADD_FRONT = 4'd1,
		FN_ADD_AT    = 4'd2,
		FN_RM_BACK   = 4'd3,
		FN_RM_FRONT  = 4'd4,
		FN_RM_AT     = 4'd5,
		FN_ISIN      = 4'd6,
		FN_GET       = 4'd7,
		FN_INDEXOF   = 4'd8,
		FN_LENGTH    = 4'd9
	} iol_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} iol_status_t;

	// What every cell does in the current cycle.
	typedef enum logic [2:0] {
		OP_HOLD      = 3'd0,
		OP_INSERT    = 3'd1,
		OP_REMOVE    = 3'd2,
		OP_MATCH_VAL = 3'd3,
		OP_MATCH_IDX = 3'd4
	} iol_op_t;

	typedef struct packed {
		iol_op_t           op;
		logic [DATA_W-1:0] key;
	} iol_cmd_t;

endpackage

FILE: design/iol_cell.sv
// ----------------------------------------------------------------------------
// iol_cell: one slot of the list
// Holds one element, shifts toward or away from the front on insert and
// remove, and carries one stage of the search lane.
// ----------------------------------------------------------------------------
module iol_cell #(
	parameter int CAPACITY = 64,
	parameter int IDX      = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iol_pkg::iol_cmd_t             cmd,
	input  logic [$clog2(CAPACITY)-1:0]   k,
	input  logic [$clog2(CAPACITY+1)-1:0] occ,
	input  logic [iol_pkg::DATA_W-1:0]    left_data,
	input  logic [iol_pkg::DATA_W-1:0]    right_data,
	output logic [iol_pkg::DATA_W-1:0]    data,
	input  logic                          lane_in_valid,
	input  logic                          lane_in_hit,
	input  logic [$clog2(CAPACITY+1)-1:0] lane_in_pos,
	input  logic [iol_pkg::DATA_W-1:0]    lane_in_data,
	output logic                          lane_valid,
	output logic                          lane_hit,
	output logic [$clog2(CAPACITY+1)-1:0] lane_pos,
	output logic [iol_pkg::DATA_W-1:0]    lane_data
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX + 1);

	logic [iol_pkg::DATA_W-1:0] data_q;
	logic                       lane_valid_q;
	logic                       lane_hit_q;
	logic [CNT_W-1:0]           lane_pos_q;
	logic [iol_pkg::DATA_W-1:0] lane_data_q;
	logic                       match;

	always_comb begin
		match = 1'b0;
		case (cmd.op)
			iol_pkg::OP_MATCH_VAL: match = (MY_CNT < occ) && (data_q == cmd.key);
			iol_pkg::OP_MATCH_IDX: match = (MY_IDX == k);
			default:               match = 1'b0;
		endcase
	end

	// element store: insert pulls from the left, remove from the right
	always_ff @(posedge clk) begin
		case (cmd.op)
			iol_pkg::OP_INSERT: begin
				if (MY_IDX > k) begin
					data_q <= left_data;
				end else if (MY_IDX == k) begin
					data_q <= cmd.key;
				end
			end
			iol_pkg::OP_REMOVE: begin
				if (MY_IDX >= k) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_valid_q <= 1'b0;
		end else begin
			lane_valid_q <= lane_in_valid;
		end
	end

	// first hit wins; later cells pass it on unchanged
	always_ff @(posedge clk) begin
		if (lane_in_valid) begin
			if (!lane_in_hit && match) begin
				lane_hit_q  <= 1'b1;
				lane_pos_q  <= MY_POS;
				lane_data_q <= data_q;
			end else begin
				lane_hit_q  <= lane_in_hit;
				lane_pos_q  <= lane_in_pos;
				lane_data_q <= lane_in_data;
			end
		end
	end

	assign data       = data_q;
	assign lane_valid = lane_valid_q;
	assign lane_hit   = lane_hit_q;
	assign lane_pos   = lane_pos_q;
	assign lane_data  = lane_data_q;

endmodule

FILE: design/iol_ctrl.sv
// ----------------------------------------------------------------------------
// iol_ctrl: request sequencer of the ordered list
// Takes one request, checks it against the occupancy, drives the cell row,
// collects the search lane and holds the result register.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_defines.svh"

module iol_ctrl #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [iol_pkg::FUNC_W-1:0]        func,
	input  logic signed [iol_pkg::DATA_W-1:0] value,
	input  logic [iol_pkg::POS_W-1:0]         position,
	output iol_pkg::iol_cmd_t                 cmd,
	output logic [$clog2(CAPACITY)-1:0]       k,
	output logic [$clog2(CAPACITY+1)-1:0]     occ,
	output logic                              lane_launch,
	input  logic                              lane_exit,
	input  logic                              lane_hit,
	input  logic [$clog2(CAPACITY+1)-1:0]     lane_pos,
	input  logic [iol_pkg::DATA_W-1:0]        lane_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [iol_pkg::STATUS_W-1:0]      status,
	output logic signed [iol_pkg::DATA_W-1:0] data_out,
	output logic                              found,
	output logic [$clog2(CAPACITY+1)-1:0]     found_position,
	output logic [$clog2(CAPACITY+1)-1:0]     length
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                      state_q, state_d;
	logic [iol_pkg::FUNC_W-1:0]  func_q;
	logic [iol_pkg::DATA_W-1:0]  value_q;
	logic [iol_pkg::POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]            occ_q;

	iol_pkg::iol_status_t        res_status_q;
	logic [iol_pkg::DATA_W-1:0]  res_data_q;
	logic                        res_found_q;
	logic [CNT_W-1:0]            res_fpos_q;
	logic [CNT_W-1:0]            res_len_q;

	logic                        out_valid_q;
	iol_pkg::iol_status_t        out_status_q;
	logic [iol_pkg::DATA_W-1:0]  out_data_q;
	logic                        out_found_q;
	logic [CNT_W-1:0]            out_fpos_q;
	logic [CNT_W-1:0]            out_len_q;

	logic                        accept;
	logic                        load_out;
	logic [CMP_W-1:0]            pos_ext;
	logic [CMP_W-1:0]            occ_ext;
	logic                        pos_ok_add;
	logic                        pos_ok_get;
	logic                        full;
	logic                        empty;
	logic [CNT_W-1:0]            pos_m1;
	logic                        do_ins;
	logic                        do_rem;
	logic                        do_mval;
	logic                        do_midx;
	logic                        sweep;
	logic                        is_indexof;
	iol_pkg::iol_status_t        pre_status;
	logic [CNT_W-1:0]            k_full;

	iol_pkg::iol_status_t        sw_status;
	logic [iol_pkg::DATA_W-1:0]  sw_data;
	logic                        sw_found;
	logic [CNT_W-1:0]            sw_fpos;
	logic [CNT_W-1:0]            sw_len;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign pos_ext    = CMP_W'(pos_q);
	assign occ_ext    = CMP_W'(occ_q);
	assign pos_ok_add = (pos_q != '0) && (pos_ext <= occ_ext + CMP_W'(1));
	assign pos_ok_get = (pos_q != '0) && (pos_ext <= occ_ext);
	assign full       = (occ_q == CNT_W'(CAPACITY));
	assign empty      = (occ_q == '0);
	assign pos_m1     = CNT_W'(pos_q) - CNT_W'(1);
	assign is_indexof = (iol_pkg::iol_func_t'(func_q) == iol_pkg::FN_INDEXOF);

	// request decode against the current occupancy
	always_comb begin
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		do_mval    = 1'b0;
		do_midx    = 1'b0;
		pre_status = iol_pkg::ST_OK;
		k_full     = '0;
		unique case (iol_pkg::iol_func_t'(func_q))
			iol_pkg::FN_ADD_BACK: begin
				if (full) begin
					pre_status = iol_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					k_full = occ_q;
				end
			end
			iol_pkg::FN_ADD_FRONT: begin
				if (full) begin
					pre_status = iol_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			iol_pkg::FN_ADD_AT: begin
				if (!pos_ok_add) begin
					pre_status = iol_pkg::ST_MISS;
				end else if (full) begin
					pre_status = iol_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					k_full = pos_m1;
				end
			end
			iol_pkg::FN_RM_BACK: begin
				if (empty) begin
					pre_status = iol_pkg::ST_MISS;
				end else begin
					do_rem = 1'b1;
					k_full = occ_q - CNT_W'(1);
				end
			end
			iol_pkg::FN_RM_FRONT: begin
				if (empty) begin
					pre_status = iol_pkg::ST_MISS;
				end else begin
					do_rem = 1'b1;
				end
			end
			iol_pkg::FN_RM_AT: begin
				if (!pos_ok_get) begin
					pre_status = iol_pkg::ST_MISS;
				end else begin
					do_rem = 1'b1;
					k_full = pos_m1;
				end
			end
			iol_pkg::FN_ISIN: begin
				do_mval = 1'b1;
			end
			iol_pkg::FN_GET: begin
				if (!pos_ok_get) begin
					pre_status = iol_pkg::ST_MISS;
				end else begin
					do_midx = 1'b1;
					k_full  = pos_m1;
				end
			end
			iol_pkg::FN_INDEXOF: begin
				do_mval = 1'b1;
			end
			iol_pkg::FN_LENGTH: begin
			end
			default: begin
				pre_status = iol_pkg::ST_MISS;
			end
		endcase
	end

	assign sweep = do_rem || do_mval || do_midx;
	assign k     = k_full[IDX_W-1:0];
	assign occ   = occ_q;

	// removal and reads fetch the element through the lane first; the
	// shift of a removal happens in the cycle the lane comes out
	always_comb begin
		cmd.key = value_q;
		cmd.op  = iol_pkg::OP_HOLD;
		if (state_q == S_EXEC) begin
			if (do_ins) begin
				cmd.op = iol_pkg::OP_INSERT;
			end else if (do_mval) begin
				cmd.op = iol_pkg::OP_MATCH_VAL;
			end else if (do_rem || do_midx) begin
				cmd.op = iol_pkg::OP_MATCH_IDX;
			end
		end else if (state_q == S_SWEEP) begin
			if (lane_exit && do_rem) begin
				cmd.op = iol_pkg::OP_REMOVE;
			end else if (do_mval) begin
				cmd.op = iol_pkg::OP_MATCH_VAL;
			end else begin
				cmd.op = iol_pkg::OP_MATCH_IDX;
			end
		end
	end

	assign lane_launch = (state_q == S_EXEC) && sweep;

	always_comb begin
		sw_status = iol_pkg::ST_OK;
		sw_data   = lane_data;
		sw_found  = 1'b0;
		sw_fpos   = '0;
		sw_len    = occ_q;
		if (do_rem) begin
			sw_len = occ_q - CNT_W'(1);
		end
		if (do_mval) begin
			sw_data  = '0;
			sw_found = lane_hit;
			if (is_indexof) begin
				if (lane_hit) begin
					sw_fpos = lane_pos;
				end else begin
					sw_status = iol_pkg::ST_MISS;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC:  state_d = sweep ? S_SWEEP : S_DONE;
			S_SWEEP: if (lane_exit) state_d = S_DONE;
			S_DONE:  if (load_out) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_EXEC) && do_ins) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if ((state_q == S_SWEEP) && lane_exit && do_rem) begin
				occ_q <= occ_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			value_q <= value;
			pos_q   <= position;
		end
		if ((state_q == S_EXEC) && !sweep) begin
			res_status_q <= pre_status;
			res_data_q   <= '0;
			res_found_q  <= 1'b0;
			res_fpos_q   <= '0;
			res_len_q    <= do_ins ? (occ_q + CNT_W'(1)) : occ_q;
		end else if ((state_q == S_SWEEP) && lane_exit) begin
			res_status_q <= sw_status;
			res_data_q   <= sw_data;
			res_found_q  <= sw_found;
			res_fpos_q   <= sw_fpos;
			res_len_q    <= sw_len;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_found_q  <= res_found_q;
			out_fpos_q   <= res_fpos_q;
			out_len_q    <= res_len_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign data_out       = out_data_q;
	assign found          = out_found_q;
	assign found_position = out_fpos_q;
	assign length         = out_len_q;

	`IOL_ASSERT_NEXT(a_accept_exec, (in_valid && !in_stall), (state_q == S_EXEC))
	`IOL_ASSERT(a_occ_step, (occ_q != $past(occ_q)) |-> (($past(state_q) == S_EXEC) || ($past(state_q) == S_SWEEP)))
	`IOL_ASSERT(a_lane_exit, lane_exit |-> (state_q == S_SWEEP))

endmodule

FILE: design/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list: bounded ordered list of signed 32-bit values
// Requests add or remove at the back, front or a 1-based position, test
// membership, read at a position, find a value or report the length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with func, value, position. A
//   transaction completes at an edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with status, data_out, found,
//   found_position and length; one result transaction per request.
//   One request is in flight at a time. Adds, length queries and rejected
//   requests pass from accept through the execute and done states. Remove,
//   read, membership and index search walk a lane through the row of
//   cells, one cell per cycle, in the sweep state; the next request is taken
//   once the result moves from the done state into the output register.
//   The result sits in an output register: while the receiver stalls, the
//   block still takes the next request and works on it; it holds that
//   second result until the register frees up.
//   Reset empties the list (occupancy 0) and clears both valids; slots stay.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_defines.svh"

module indexed_ordered_list #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [iol_pkg::FUNC_W-1:0]        func,
	input  logic signed [iol_pkg::DATA_W-1:0] value,
	input  logic [iol_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [iol_pkg::STATUS_W-1:0]      status,
	output logic signed [iol_pkg::DATA_W-1:0] data_out,
	output logic                              found,
	output logic [$clog2(CAPACITY+1)-1:0]     found_position,
	output logic [$clog2(CAPACITY+1)-1:0]     length
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// command broadcast from the sequencer to every cell
	iol_pkg::iol_cmd_t          cmd;
	logic [IDX_W-1:0]           k;
	logic [CNT_W-1:0]           occ;

	// element i of the list (1-based position i+1) lives in cell i
	logic [iol_pkg::DATA_W-1:0] cell_data [CAPACITY];

	// search lane: stage 0 is the launch, stage CAPACITY is the exit
	logic [CAPACITY:0]          lane_valid;
	logic [CAPACITY:0]          lane_hit;
	logic [CNT_W-1:0]           lane_pos  [CAPACITY+1];
	logic [iol_pkg::DATA_W-1:0] lane_data [CAPACITY+1];
	logic                       lane_launch;

	iol_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.value         (value),
		.position      (position),
		.cmd           (cmd),
		.k             (k),
		.occ           (occ),
		.lane_launch   (lane_launch),
		.lane_exit     (lane_valid[CAPACITY]),
		.lane_hit      (lane_hit[CAPACITY]),
		.lane_pos      (lane_pos[CAPACITY]),
		.lane_data     (lane_data[CAPACITY]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.data_out      (data_out),
		.found         (found),
		.found_position(found_position),
		.length        (length)
	);

	// lane enters empty at the front cell
	assign lane_valid[0] = lane_launch;
	assign lane_hit[0]   = 1'b0;
	assign lane_pos[0]   = '0;
	assign lane_data[0]  = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		// neighbors; the end cells read themselves where no neighbor exists
		localparam int LEFT  = (i == 0) ? 0 : i - 1;
		localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

		iol_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.k            (k),
			.occ          (occ),
			.left_data    (cell_data[LEFT]),
			.right_data   (cell_data[RIGHT]),
			.data         (cell_data[i]),
			.lane_in_valid(lane_valid[i]),
			.lane_in_hit  (lane_hit[i]),
			.lane_in_pos  (lane_pos[i]),
			.lane_in_data (lane_data[i]),
			.lane_valid   (lane_valid[i+1]),
			.lane_hit     (lane_hit[i+1]),
			.lane_pos     (lane_pos[i+1]),
			.lane_data    (lane_data[i+1])
		);
	end

	// a full list is only reported with the length at capacity
	`IOL_ASSERT(a_full_len, (out_valid && (status == iol_pkg::ST_FULL)) |-> (length == CNT_W'(CAPACITY)))
	// failed requests never return an element
	`IOL_ASSERT(a_miss_data, (out_valid && (status != iol_pkg::ST_OK)) |-> (data_out == '0))

endmodule
